FILE: design/pva_pkg.sv
`default_nettype none
package pva_pkg;

    localparam int COORD_WIDTH  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int INDEX_WIDTH  = 16;

    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int CW        = 64;
    localparam int PRE_SHIFT = 60 - COORD_WIDTH;
    localparam int ZW        = 26;
    localparam int ANGLE_W   = 15;
    localparam int TAB_W     = 22;
    localparam int TAB_LEN   = 24;
    localparam int TAB_IDX_W = $clog2(TAB_LEN);

    localparam logic [ANGLE_W-1:0]     ANGLE_MAX = ANGLE_W'(23040);
    localparam logic [ZW-1:0]          DEG90     = ZW'(90 * 65536);
    localparam logic [ZW-1:0]          DEG180    = ZW'(180 * 65536);
    localparam logic [ZW-1:0]          DEG360    = ZW'(360 * 65536);
    localparam logic [INDEX_WIDTH-1:0] INDEX_TOP = {INDEX_WIDTH{1'b1}};

    localparam logic [TAB_W-1:0] ATAN_TAB [0:TAB_LEN-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    typedef enum logic [2:0] {
        J_PREV  = 3'd0,
        J_WRAP  = 3'd1,
        J_FIRST = 3'd2,
        J_ZERO0 = 3'd3,
        J_ZERO1 = 3'd4
    } t_job;

    typedef struct packed {
        logic              load;
        logic              setup;
        logic              side;
        logic              iterate;
        logic [STEP_W-1:0] step;
        logic              save;
        logic              fold;
        logic              emit;
        t_job              job;
        logic              finish;
    } t_cmd;

    typedef struct packed {
        logic k_is0;
        logic k_is1;
        logic closes;
        logic out_free;
    } t_stat;

    function automatic logic signed [ZW-1:0] bearing(input logic zero,
                                                     input logic signed [ZW-1:0] z);
        logic signed [ZW-1:0] b;
        b = zero ? '0 : z;
        if (b <= 0) begin
            b = b + $signed(DEG360);
        end
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: design/pva_datapath.sv
`default_nettype none
module pva_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire pva_pkg::t_cmd                         i_cmd,
    output pva_pkg::t_stat                             o_stat,
    input  wire logic signed [pva_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [pva_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  wire logic                                  i_closes_polygon,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [pva_pkg::INDEX_WIDTH-1:0]            o_vertex_index,
    output logic [pva_pkg::ANGLE_W-1:0]                o_angle_q7,
    output logic                                       o_last_result
);
    localparam int N  = pva_pkg::COORD_WIDTH;
    localparam int CW = pva_pkg::CW;
    localparam int ZW = pva_pkg::ZW;

    logic signed [N-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic signed [N-1:0] r_older_x, r_older_y, r_newer_x, r_newer_y;
    logic signed [N-1:0] r_cur_x, r_cur_y;
    logic                r_cur_last;
    logic [pva_pkg::INDEX_WIDTH-1:0] r_count;

    logic signed [CW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z, r_b1;
    logic                 r_zero, n_zero;
    logic [pva_pkg::ANGLE_W-1:0] r_angle;

    logic                            r_out_valid;
    logic [pva_pkg::INDEX_WIDTH-1:0] r_out_index;
    logic [pva_pkg::ANGLE_W-1:0]     r_out_angle;
    logic                            r_out_last;

    logic signed [N-1:0]  p_x, p_y, c_x, c_y, q_x, q_y, o_x, o_y;
    logic signed [N:0]    dx, dy;
    logic signed [CW-1:0] ex, ey, xs, ys;
    logic signed [ZW-1:0] tab, b2;
    logic signed [ZW:0]   d_raw;
    logic [ZW-1:0]        d_abs, d_fold;
    logic [ZW-9:0]        q;
    logic [pva_pkg::ANGLE_W-1:0]     angle_fold;
    logic [pva_pkg::INDEX_WIDTH-1:0] prev_idx, e_index;
    logic                            e_last;
    logic [pva_pkg::ANGLE_W-1:0]     e_angle;

    always_comb begin
        unique case (i_cmd.job)
            pva_pkg::J_WRAP: begin
                p_x = r_newer_x; p_y = r_newer_y; c_x = r_cur_x; c_y = r_cur_y;
                q_x = r_first_x; q_y = r_first_y;
            end
            pva_pkg::J_FIRST: begin
                p_x = r_cur_x; p_y = r_cur_y; c_x = r_first_x; c_y = r_first_y;
                q_x = r_second_x; q_y = r_second_y;
            end
            default: begin
                p_x = r_older_x; p_y = r_older_y; c_x = r_newer_x; c_y = r_newer_y;
                q_x = r_cur_x; q_y = r_cur_y;
            end
        endcase
        o_x = i_cmd.side ? q_x : p_x;
        o_y = i_cmd.side ? q_y : p_y;
        dx  = {o_x[N-1], o_x} - {c_x[N-1], c_x};
        dy  = {o_y[N-1], o_y} - {c_y[N-1], c_y};
        ex  = {{(CW-N-1){dx[N]}}, dx} <<< pva_pkg::PRE_SHIFT;
        ey  = {{(CW-N-1){dy[N]}}, dy} <<< pva_pkg::PRE_SHIFT;
    end

    assign xs  = r_x >>> i_cmd.step;
    assign ys  = r_y >>> i_cmd.step;
    assign tab = $signed({{(ZW-pva_pkg::TAB_W){1'b0}},
                          pva_pkg::ATAN_TAB[pva_pkg::TAB_IDX_W'(i_cmd.step)]});

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        n_zero = r_zero;
        if (i_cmd.setup) begin
            n_zero = (dx == '0) && (dy == '0);
            n_x = ey;
            n_y = ex;
            n_z = '0;
            if (ey[CW-1]) begin
                if (!ex[CW-1]) begin
                    n_x = ex;
                    n_y = -ey;
                    n_z = $signed(pva_pkg::DEG90);
                end else begin
                    n_x = -ex;
                    n_y = ey;
                    n_z = -$signed(pva_pkg::DEG90);
                end
            end
        end else if (i_cmd.iterate) begin
            if (!r_y[CW-1]) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + tab;
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - tab;
            end
        end
    end

    always_comb begin
        b2     = pva_pkg::bearing(r_zero, r_z);
        d_raw  = {r_b1[ZW-1], r_b1} - {b2[ZW-1], b2};
        d_abs  = d_raw[ZW] ? ZW'(-d_raw) : d_raw[ZW-1:0];
        d_fold = (d_abs > pva_pkg::DEG180) ? pva_pkg::DEG360 - d_abs : d_abs;
        q      = (ZW-8)'((d_fold + ZW'(256)) >> 9);
        angle_fold = (q > (ZW-8)'(pva_pkg::ANGLE_MAX)) ? pva_pkg::ANGLE_MAX
                                                         : pva_pkg::ANGLE_W'(q);
    end

    always_comb begin
        prev_idx = (r_count == pva_pkg::INDEX_TOP) ? pva_pkg::INDEX_TOP
                                                   : r_count - 1'b1;
        e_angle = r_angle;
        e_last  = 1'b0;
        unique case (i_cmd.job)
            pva_pkg::J_PREV:  e_index = prev_idx;
            pva_pkg::J_WRAP:  e_index = r_count;
            pva_pkg::J_FIRST: begin
                e_index = '0;
                e_last  = 1'b1;
            end
            pva_pkg::J_ZERO0: begin
                e_index = '0;
                e_angle = '0;
                e_last  = (r_count == '0);
            end
            default: begin
                e_index = pva_pkg::INDEX_WIDTH'(1);
                e_angle = '0;
                e_last  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_zero <= n_zero;
        if (i_cmd.save) begin
            r_b1 <= pva_pkg::bearing(r_zero, r_z);
        end
        if (i_cmd.fold) begin
            r_angle <= angle_fold;
        end
        if (i_cmd.load) begin
            r_cur_x    <= i_x_coord;
            r_cur_y    <= i_y_coord;
            r_cur_last <= i_closes_polygon;
        end
        if (i_cmd.emit) begin
            r_out_index <= e_index;
            r_out_angle <= e_angle;
            r_out_last  <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_x  <= '0; r_first_y  <= '0;
            r_second_x <= '0; r_second_y <= '0;
            r_older_x  <= '0; r_older_y  <= '0;
            r_newer_x  <= '0; r_newer_y  <= '0;
            r_count    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_older_x <= r_newer_x;
                r_older_y <= r_newer_y;
                r_newer_x <= r_cur_x;
                r_newer_y <= r_cur_y;
                if (r_count == '0) begin
                    r_first_x <= r_cur_x;
                    r_first_y <= r_cur_y;
                end
                if (r_count == pva_pkg::INDEX_WIDTH'(1)) begin
                    r_second_x <= r_cur_x;
                    r_second_y <= r_cur_y;
                end
                if (r_cur_last) begin
                    r_count <= '0;
                end else if (r_count != pva_pkg::INDEX_TOP) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.k_is0    = (r_count == '0);
    assign o_stat.k_is1    = (r_count == pva_pkg::INDEX_WIDTH'(1));
    assign o_stat.closes   = r_cur_last;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_angle_q7     = r_out_angle;
    assign o_last_result  = r_out_last;
endmodule
`default_nettype wire

FILE: design/pva_controller.sv
`default_nettype none
module pva_controller (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire pva_pkg::t_stat i_stat,
    output pva_pkg::t_cmd       o_cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHOOSE = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_ITER   = 8'b0000_1000,
        S_SAVE   = 8'b0001_0000,
        S_FOLD   = 8'b0010_0000,
        S_EMIT   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    localparam logic [pva_pkg::STEP_W-1:0] STEP_LAST =
        pva_pkg::STEP_W'(pva_pkg::CORDIC_STEPS - 1);

    t_state                      r_state, n_state;
    pva_pkg::t_job               r_job, n_job;
    logic                        r_side, n_side;
    logic [pva_pkg::STEP_W-1:0]  r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_side  = r_side;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                n_side = 1'b0;
                if (!i_stat.k_is0 && !i_stat.k_is1) begin
                    n_job   = pva_pkg::J_PREV;
                    n_state = S_SETUP;
                end else if (i_stat.closes) begin
                    n_job   = pva_pkg::J_ZERO0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SETUP: begin
                n_step  = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                if (r_step == STEP_LAST) begin
                    n_state = r_side ? S_FOLD : S_SAVE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SAVE: begin
                n_side  = 1'b1;
                n_state = S_SETUP;
            end
            S_FOLD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_side  = 1'b0;
                    n_state = S_FINISH;
                    if (r_job == pva_pkg::J_PREV && i_stat.closes) begin
                        n_job   = pva_pkg::J_WRAP;
                        n_state = S_SETUP;
                    end else if (r_job == pva_pkg::J_WRAP) begin
                        n_job   = pva_pkg::J_FIRST;
                        n_state = S_SETUP;
                    end else if (r_job == pva_pkg::J_ZERO0 && i_stat.k_is1) begin
                        n_job = pva_pkg::J_ZERO1;
                        n_state = S_EMIT;
                    end
                end
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= pva_pkg::J_PREV;
            r_side  <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_side  <= n_side;
            r_step  <= n_step;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.setup   = (r_state == S_SETUP);
    assign o_cmd.side    = r_side;
    assign o_cmd.iterate = (r_state == S_ITER);
    assign o_cmd.step    = r_step;
    assign o_cmd.save    = (r_state == S_SAVE);
    assign o_cmd.fold    = (r_state == S_FOLD);
    assign o_cmd.emit    = (r_state == S_EMIT) && i_stat.out_free;
    assign o_cmd.job     = r_job;
    assign o_cmd.finish  = (r_state == S_FINISH);

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result written while output register is occupied");

    a_first_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.iterate && r_step == '0) |-> $past(r_state == S_SETUP))
        else $error("rotation started without vector setup");

    a_finish_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after an item");

    a_load_choose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHOOSE))
        else $error("accepted item not dispatched");
endmodule
`default_nettype wire

FILE: design/polygon_vertex_angle_unit.sv
// An item's first angle result takes two 16-step rotations of one shared vectoring unit,
// plus setup and fold. A closing vertex can give three angles, all from the single rotation
// unit; an output stall holds it at emit. No new item is taken while one is at work.
// Reset (synchronous, active low) clears the stored vertices, vertex count and output valid.
`default_nettype none
module polygon_vertex_angle_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic signed [pva_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [pva_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  wire logic                                   i_closes_polygon,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [pva_pkg::INDEX_WIDTH-1:0]             o_vertex_index,
    output logic [pva_pkg::ANGLE_W-1:0]                 o_angle_q7,
    output logic                                        o_last_result
);
    pva_pkg::t_cmd  cmd;
    pva_pkg::t_stat stat;

    pva_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pva_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_x_coord        (i_x_coord),
        .i_y_coord        (i_y_coord),
        .i_closes_polygon (i_closes_polygon),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_vertex_index   (o_vertex_index),
        .o_angle_q7       (o_angle_q7),
        .o_last_result    (o_last_result)
    );
endmodule
`default_nettype wire
